>>> design/bscr_pkg.sv
// ----------------------------------------------------------------------------
// Battery status responder package
// Shared types, constants and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package bscr_pkg;

   localparam int CellCountWidth = 6;
   localparam logic [CellCountWidth-1:0] CellCountReset = 6'd20;

   localparam int FrameIdWidth = 29;
   localparam int RespIdWidth  = 9;
   localparam int LengthWidth  = 4;
   localparam int ReqDataWidth = 32;
   localparam int ReqUserWidth = 3;
   localparam int RspDataWidth = 80;

   // Request identifiers 0x100 to 0x107 share these upper bits.
   localparam logic [FrameIdWidth-4:0] IdUpperMatch = 26'h20;
   localparam logic [RespIdWidth-4:0]  RespIdUpper  = 6'h20;

   // Low three bits of the request identifier.
   localparam logic [2:0] SelVoltage  = 3'd0;
   localparam logic [2:0] SelLimits   = 3'd1;
   localparam logic [2:0] SelStatus   = 3'd2;
   localparam logic [2:0] SelCapacity = 3'd3;
   localparam logic [2:0] SelCells    = 3'd4;
   localparam logic [2:0] SelUnused   = 3'd7;

   localparam logic [LengthWidth-1:0] LengthLong  = 4'd8;
   localparam logic [LengthWidth-1:0] LengthShort = 4'd4;

   localparam logic [8:0]  VoltsPerCell = 9'd325;
   localparam logic [15:0] CrcInit      = 16'hFFFF;
   localparam logic [15:0] CrcPoly      = 16'hA001;

   // Stage 0 decodes, stages 1 to 6 each fold one payload byte into the CRC.
   localparam int NumStages = 7;

   typedef struct packed {
      logic [2:0]      sel;
      logic            short_frame;
      logic [7:0][7:0] data;
      logic [15:0]     crc;
   } stage_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_old,
                                            input logic [7:0]  data_byte);
      logic [15:0] crc;
      crc = crc_old ^ {8'h00, data_byte};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CrcPoly;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

>>> design/battery_status_can_responder_core.sv
// ----------------------------------------------------------------------------
// Battery status CAN responder core
// Answers classic standard-ID remote requests 0x100 to 0x106 with one
// fixed-layout status frame closed by a CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// The core takes one request beat per cycle while the result side is not
// stalled, and passes each one through one decode stage, six CRC stages
// that each fold one payload byte, and the output register. The CRC byte
// chain sets the pipeline depth. Requests that do not qualify (data frame,
// extended or FD format, other identifier, or no transmit space) are
// accepted and dropped without a response beat. The cell count register is
// sampled when a request enters the pipeline.
module battery_status_can_responder_core
   import bscr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_wr_en,
   input  logic [CellCountWidth-1:0] csr_wr_data,

   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [28:0] frame_id, [29] tx_space, [31:30] zero
   input  logic [ReqDataWidth-1:0]   req_tdata,
   // [0] is_remote, [1] is_extended, [2] is_fd
   input  logic [ReqUserWidth-1:0]   req_tuser,

   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [8:0] resp_id, [12:9] resp_length, [20:13] byte0 ... [76:69] byte7,
   // [79:77] zero
   output logic [RspDataWidth-1:0]   rsp_tdata
);

   logic [CellCountWidth-1:0] cell_count_ff;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   stage_type            stage_ff [NumStages];
   stage_type            stage_in [NumStages];
   logic [NumStages:0]   advance;

   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;
   logic [RspDataWidth-1:0] rsp_data_in;

   logic [FrameIdWidth-1:0] frame_id;
   logic                    qualified;
   logic [15:0]             volts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= CellCountReset;
      end else if (csr_wr_en) begin
         cell_count_ff <= csr_wr_data;
      end
   end

   assign frame_id = req_tdata[FrameIdWidth-1:0];

   assign qualified = req_tuser[0] && !req_tuser[1] && !req_tuser[2] &&
                      req_tdata[FrameIdWidth] &&
                      (frame_id[FrameIdWidth-1:3] == IdUpperMatch) &&
                      (frame_id[2:0] != SelUnused);

   assign volts = 16'(cell_count_ff) * 16'(VoltsPerCell);

   // A stage takes a new beat when it is empty or its contents move on.
   always_comb begin
      advance[NumStages] = !rsp_valid_ff || rsp_tready;
      for (int s = NumStages - 1; s >= 0; s--) begin
         advance[s] = !valid_ff[s] || advance[s+1];
      end
   end

   assign req_tready = advance[0];

   // Decode stage input.
   always_comb begin
      valid_in[0]             = req_tvalid && qualified;
      stage_in[0].sel         = frame_id[2:0];
      stage_in[0].short_frame = 1'b0;
      stage_in[0].data        = '0;
      stage_in[0].crc         = CrcInit;
      case (frame_id[2:0])
         SelVoltage: begin
            stage_in[0].data[0] = volts[15:8];
            stage_in[0].data[1] = volts[7:0];
            stage_in[0].data[3] = 8'h64;
            stage_in[0].data[4] = 8'h03;
            stage_in[0].data[5] = 8'hE8;
         end
         SelLimits: begin
            stage_in[0].data[0] = 8'h03;
            stage_in[0].data[1] = 8'hE8;
            stage_in[0].data[3] = 8'h0A;
            stage_in[0].data[5] = 8'h4B;
         end
         SelStatus: begin
            stage_in[0].data = '0;
         end
         SelCapacity: begin
            stage_in[0].data[1] = 8'h03;
            stage_in[0].data[2] = 8'h20;
            stage_in[0].data[3] = 8'h68;
            stage_in[0].data[5] = 8'h03;
         end
         SelCells: begin
            stage_in[0].data[0]     = {2'b00, cell_count_ff};
            stage_in[0].data[1]     = 8'h04;
            stage_in[0].short_frame = 1'b1;
         end
         default: begin
            stage_in[0].data[0] = 8'h0B;
            stage_in[0].data[1] = 8'hA4;
            stage_in[0].data[2] = 8'h0B;
            stage_in[0].data[3] = 8'hA4;
            stage_in[0].data[4] = 8'h0B;
            stage_in[0].data[5] = 8'hA4;
         end
      endcase
   end

   // CRC stages: stage s folds payload byte s-1. The short frame only covers
   // its first two bytes.
   for (genvar s = 1; s < NumStages; s++) begin : g_crc_stage
      always_comb begin
         valid_in[s] = valid_ff[s-1];
         stage_in[s] = stage_ff[s-1];
         if (!stage_ff[s-1].short_frame || (s < 3)) begin
            stage_in[s].crc = crc_byte(stage_ff[s-1].crc, stage_ff[s-1].data[s-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NumStages; s++) begin
            if (advance[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NumStages; s++) begin
         if (advance[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   // Place the CRC behind the payload and pack the response beat.
   always_comb begin
      stage_type last;
      last = stage_ff[NumStages-1];
      if (last.short_frame) begin
         last.data[2] = last.crc[15:8];
         last.data[3] = last.crc[7:0];
      end else begin
         last.data[6] = last.crc[15:8];
         last.data[7] = last.crc[7:0];
      end
      rsp_data_in = '0;
      rsp_data_in[RespIdWidth-1:0] = {RespIdUpper, last.sel};
      rsp_data_in[RespIdWidth +: LengthWidth] = last.short_frame ? LengthShort : LengthLong;
      for (int k = 0; k < 8; k++) begin
         rsp_data_in[RespIdWidth + LengthWidth + 8*k +: 8] = last.data[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance[NumStages]) begin
         rsp_valid_ff <= valid_ff[NumStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[NumStages]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/bscr_checker.sv
// ----------------------------------------------------------------------------
// Battery status responder checker
// Port-level checks on the response channel, bound to the core.
// ----------------------------------------------------------------------------
module bscr_checker
   import bscr_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata
);

   logic [RespIdWidth-1:0] rsp_id;
   logic [LengthWidth-1:0] rsp_len;

   assign rsp_id  = rsp_tdata[RespIdWidth-1:0];
   assign rsp_len = rsp_tdata[RespIdWidth +: LengthWidth];

   // A stalled response beat must hold until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("response beat dropped or changed while stalled");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_id[RespIdWidth-1:3] == RespIdUpper) &&
                     (rsp_id[2:0] != SelUnused))
      else $error("response identifier outside 0x100 to 0x106");

   a_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_len == LengthShort) == (rsp_id[2:0] == SelCells)) &&
                     ((rsp_len == LengthShort) || (rsp_len == LengthLong)))
      else $error("response length does not match identifier");

   // The short frame leaves its upper four bytes empty.
   a_short_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_len == LengthShort)) |->
         (rsp_tdata[RspDataWidth-1:RespIdWidth + LengthWidth + 32] == '0))
      else $error("short response carries data past its length");

endmodule

bind battery_status_can_responder_core bscr_checker u_bscr_checker (.*);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Battery status CAN responder testbench
// Sends request frame headers through a stream driver with random gaps,
// predicts each status response, and checks every response beat field by
// field against the oldest pending prediction. The cell count register is
// changed between phases, once the core has drained.
// ----------------------------------------------------------------------------
module tb_top
   import bscr_pkg::*;
();

   localparam int StallLimit   = 2000;
   localparam int DrainCycles  = 16;
   localparam int PhaseItems   = 80;
   localparam int IdlePercent  = 28;

   typedef struct packed {
      logic [FrameIdWidth-1:0] frame_id;
      logic                    is_remote;
      logic                    is_extended;
      logic                    is_fd;
      logic                    tx_space;
   } can_request_type;

   typedef struct {
      logic [RespIdWidth-1:0] resp_id;
      logic [LengthWidth-1:0] resp_length;
      logic [7:0]             payload [8];
   } status_frame_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CellCountWidth-1:0] csr_wr_data;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [ReqDataWidth-1:0]   req_tdata;
   logic [ReqUserWidth-1:0]   req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RspDataWidth-1:0]   rsp_tdata;

   can_request_type           pending_requests [$];
   status_frame_type          frames_due [$];
   logic [CellCountWidth-1:0] cell_level;
   logic                      req_taken;
   logic                      gaps_on;
   int                        stall_cycles;
   int                        mismatch_count;

   battery_status_can_responder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   // CRC-16/MODBUS worked one bit at a time, least significant bit first.
   function automatic logic [15:0] modbus_crc(input logic [7:0] bytes [8], input int count);
      logic [15:0] crc;
      logic        fb;
      crc = CrcInit;
      for (int k = 0; k < count; k++) begin
         for (int b = 0; b < 8; b++) begin
            fb  = crc[0] ^ bytes[k][b];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ CrcPoly;
            end
         end
      end
      return crc;
   endfunction

   function automatic bit predict_status_frame(input can_request_type rq,
                                               input logic [CellCountWidth-1:0] cells,
                                               output status_frame_type frame);
      logic [15:0] volts;
      logic [15:0] crc;
      int          body;
      for (int k = 0; k < 8; k++) begin
         frame.payload[k] = 8'h00;
      end
      frame.resp_id     = rq.frame_id[RespIdWidth-1:0];
      frame.resp_length = LengthLong;
      if (!rq.is_remote || rq.is_extended || rq.is_fd || !rq.tx_space) begin
         return 0;
      end
      if (rq.frame_id[FrameIdWidth-1:3] != IdUpperMatch || rq.frame_id[2:0] == SelUnused) begin
         return 0;
      end
      body = 6;
      case (rq.frame_id[2:0])
         SelVoltage: begin
            volts = 16'(cells) * 16'(VoltsPerCell);
            frame.payload[0] = volts[15:8];
            frame.payload[1] = volts[7:0];
            frame.payload[3] = 8'h64;
            frame.payload[4] = 8'h03;
            frame.payload[5] = 8'hE8;
         end
         SelLimits: begin
            frame.payload[0] = 8'h03;
            frame.payload[1] = 8'hE8;
            frame.payload[3] = 8'h0A;
            frame.payload[5] = 8'h4B;
         end
         SelStatus: begin
         end
         SelCapacity: begin
            frame.payload[1] = 8'h03;
            frame.payload[2] = 8'h20;
            frame.payload[3] = 8'h68;
            frame.payload[5] = 8'h03;
         end
         SelCells: begin
            frame.payload[0] = 8'(cells);
            frame.payload[1] = 8'h04;
            frame.resp_length = LengthShort;
            body = 2;
         end
         default: begin
            for (int k = 0; k < 6; k++) begin
               frame.payload[k] = (k % 2 == 0) ? 8'h0B : 8'hA4;
            end
         end
      endcase
      crc = modbus_crc(frame.payload, body);
      frame.payload[body]     = crc[15:8];
      frame.payload[body + 1] = crc[7:0];
      return 1;
   endfunction

   function automatic can_request_type status_request(input logic [2:0] sel);
      can_request_type rq;
      rq.frame_id    = {IdUpperMatch, sel};
      rq.is_remote   = 1'b1;
      rq.is_extended = 1'b0;
      rq.is_fd       = 1'b0;
      rq.tx_space    = 1'b1;
      return rq;
   endfunction

   // Mostly well-formed status requests; the rest are random frames, identifiers
   // near the status range, or random flags, which the core may or may not drop.
   function automatic can_request_type random_request();
      can_request_type rq;
      int              pick;
      pick = $urandom_range(0, 99);
      rq = status_request(3'($urandom_range(0, 6)));
      if (pick >= 70 && pick < 80) begin
         rq.frame_id = 29'($urandom);
         {rq.is_remote, rq.is_extended, rq.is_fd, rq.tx_space} = 4'($urandom);
      end else if (pick >= 80 && pick < 90) begin
         rq.frame_id = 29'($urandom_range(32'h0F8, 32'h10F));
      end else if (pick >= 90) begin
         {rq.is_remote, rq.is_extended, rq.is_fd, rq.tx_space} = 4'($urandom);
      end
      return rq;
   endfunction

   // Request driver: a beat stays on the bus until the core takes it.
   always @(negedge clock) begin
      can_request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_requests.size() != 0
             && !(gaps_on && $urandom_range(0, 99) < IdlePercent)) begin
            rq = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {2'b00, rq.tx_space, rq.frame_id};
            req_tuser  <= {rq.is_fd, rq.is_extended, rq.is_remote};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !(gaps_on && $urandom_range(0, 99) < IdlePercent);
   end

   // Monitor: predicts on each request beat and checks each response beat.
   always @(posedge clock) begin
      can_request_type  rq;
      status_frame_type pred;
      status_frame_type want;
      logic [7:0]       got_byte;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            rq.frame_id    = req_tdata[FrameIdWidth-1:0];
            rq.tx_space    = req_tdata[FrameIdWidth];
            rq.is_remote   = req_tuser[0];
            rq.is_extended = req_tuser[1];
            rq.is_fd       = req_tuser[2];
            if (predict_status_frame(rq, cell_level, pred)) begin
               frames_due.push_back(pred);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               $error("response beat with id %0h arrived with none pending", rsp_tdata[8:0]);
               mismatch_count++;
            end else begin
               want = frames_due.pop_front();
               if (rsp_tdata[8:0] !== want.resp_id) begin
                  $error("resp_id expected %0h got %0h", want.resp_id, rsp_tdata[8:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[12:9] !== want.resp_length) begin
                  $error("resp_length expected %0d got %0d", want.resp_length,
                         rsp_tdata[12:9]);
                  mismatch_count++;
               end
               for (int k = 0; k < 8; k++) begin
                  got_byte = rsp_tdata[13 + 8*k +: 8];
                  if (got_byte !== want.payload[k]) begin
                     $error("byte%0d expected %02h got %02h", k, want.payload[k], got_byte);
                     mismatch_count++;
                  end
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Waits until every request has gone in and every response has come out,
   // then lets dropped requests clear the pipeline.
   task automatic drain_core();
      while (pending_requests.size() != 0 || req_tvalid || frames_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_cell_count(input logic [CellCountWidth-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      cell_level = value;
   endtask

   initial begin
      logic [CellCountWidth-1:0] settings [5];
      can_request_type           rq;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b1;
      gaps_on        = 1'b1;
      mismatch_count = 0;
      cell_level     = CellCountReset;
      settings       = '{6'd63, 6'd0, 6'd32, 6'($urandom), 6'd1};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset cell count: every identifier, then the
      // near misses and each disqualifying flag on its own.
      for (int s = 0; s < 7; s++) begin
         pending_requests.push_back(status_request(3'(s)));
      end
      rq = status_request(SelUnused);
      pending_requests.push_back(rq);
      rq.frame_id = 29'h0FF;
      pending_requests.push_back(rq);
      rq.frame_id = 29'h000;
      pending_requests.push_back(rq);
      rq.frame_id = 29'h1FFF_FFFF;
      pending_requests.push_back(rq);
      // Identifiers that alias 0x100 and 0x104 in their low nine bits.
      rq.frame_id = 29'h300;
      pending_requests.push_back(rq);
      rq.frame_id = 29'h1000_0104;
      pending_requests.push_back(rq);
      rq = status_request(SelVoltage);
      rq.is_remote = 1'b0;
      pending_requests.push_back(rq);
      rq = status_request(SelLimits);
      rq.is_extended = 1'b1;
      pending_requests.push_back(rq);
      rq = status_request(SelStatus);
      rq.is_fd = 1'b1;
      pending_requests.push_back(rq);
      rq = status_request(SelCapacity);
      rq.tx_space = 1'b0;
      pending_requests.push_back(rq);
      rq = '{29'h1FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0};
      pending_requests.push_back(rq);
      rq = status_request(SelCells);
      pending_requests.push_back(rq);
      pending_requests.push_back(rq);
      drain_core();

      for (int p = 0; p < 5; p++) begin
         write_cell_count(settings[p]);
         gaps_on = (p != 2);
         pending_requests.push_back(status_request(SelVoltage));
         pending_requests.push_back(status_request(SelCells));
         for (int n = 0; n < PhaseItems; n++) begin
            pending_requests.push_back(random_request());
         end
         drain_core();
      end

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
design/bscr_pkg.sv
design/battery_status_can_responder_core.sv
design/bscr_checker.sv
tb/sv/tb_top.sv
